>>> design/sw2pt_pkg.sv
// Shared package for the strip/wire to phi/theta converter.
// Holds widths, request and register codes, configuration and lane result types,
// and the fixed chamber phi start table. Depends on nothing.
`default_nettype none

package sw2pt_pkg;

  localparam int PHI_WIDTH     = 13;
  localparam int HIT_MAP_WIDTH = 44;
  localparam int ZONE_MARGIN   = 2;
  localparam int THETA_WIDTH   = 7;

  localparam int HS_W        = 8;
  localparam int WG_W        = 6;
  localparam int PAT_W       = 4;
  localparam int PHI_OUT_W   = 12;
  localparam int THETA_OUT_W = 7;
  localparam int HIT_OUT_W   = 44;
  localparam int ZONE_W      = 3;
  localparam int START_W     = PHI_WIDTH - 6;
  localparam int FACTOR_W    = 11;
  localparam int PROD_W      = PHI_WIDTH + FACTOR_W;
  localparam int SCALE_SHIFT = 10;
  localparam int RED_SHIFT   = 5;

  localparam logic [FACTOR_W-1:0] FACTOR_INNER = FACTOR_W'(1301);
  localparam logic [FACTOR_W-1:0] FACTOR_OUTER = FACTOR_W'(1707);
  localparam int HS_INNER_MAX     = 127;
  localparam int OUTER_HS_OFFSET  = 512;
  localparam int PHI_ROUND        = 16;
  localparam int THETA_CUT        = 50;
  localparam int THETA_MAX        = 45;
  localparam int ZONE_LOW_MAX     = 41 + ZONE_MARGIN;
  localparam int ZONE_HIGH_MIN    = 127 - ZONE_MARGIN;
  localparam int ZONE_MID_MIN     = 41 - ZONE_MARGIN;
  localparam int ZONE_MID_MAX     = 127 + ZONE_MARGIN;
  localparam int ZONE_LOW         = 0;
  localparam int ZONE_MID         = 1;
  localparam int ZONE_HIGH        = 2;

  localparam int WIRE_DEPTH = 64;
  localparam int WIRE_AW    = 6;
  localparam int WIRE_DW    = 6;
  localparam int CORR_DEPTH = 128;
  localparam int CORR_AW    = 7;
  localparam int CORR_DW    = 4;

  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_CONVERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WIRE_WR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CORR_WR = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] CFG_PHI_INNER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PHI_OUTER = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THETA_ORG = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STATION   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHAMBER   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE   = 3'd5;

  typedef struct packed {
    logic [11:0] phi_origin_inner;
    logic [11:0] phi_origin_outer;
    logic [6:0]  theta_origin;
    logic [2:0]  station_number;
    logic [3:0]  chamber_number;
    logic        reverse_mount;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 outer;
    logic [PHI_OUT_W-1:0] phi;
    logic [HIT_OUT_W-1:0] hit;
  } phi_res_t;

  localparam int STATIONS = 5;
  localparam int CHAMBERS = 16;

  localparam logic [7:0] CHAMBER_START [STATIONS][CHAMBERS] = '{
    '{39, 57, 76, 39, 58, 76, 41, 60, 79, 39, 57, 76, 21, 21, 23, 21},
    '{95, 114, 132, 95, 114, 133, 98, 116, 135, 95, 114, 132, 0, 0, 0, 0},
    '{38, 76, 113, 39, 58, 76, 95, 114, 132, 1, 21, 0, 0, 0, 0, 0},
    '{38, 76, 113, 39, 58, 76, 95, 114, 132, 1, 21, 0, 0, 0, 0, 0},
    '{38, 76, 113, 38, 57, 76, 95, 113, 132, 1, 20, 0, 0, 0, 0, 0}
  };

  function automatic logic [START_W-1:0] chamber_start(input logic [2:0] station,
                                                       input logic [3:0] chamber);
    logic [START_W-1:0] v;
    v = '0;
    if (station < 3'(STATIONS)) begin
      v = START_W'(CHAMBER_START[station][chamber]);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/sw2pt_phi_lane.sv
// One phi lane: eighth-strip conversion, pattern correction and scaling, then
// origin offset and hit map bit in the second stage. Depends on sw2pt_pkg.
`default_nettype none

module sw2pt_phi_lane (
  input  logic                              clk_i,
  input  logic                              ld_i,
  input  logic                              valid_i,
  input  logic [sw2pt_pkg::HS_W-1:0]        halfstrip_i,
  input  logic [sw2pt_pkg::PAT_W-1:0]       pattern_i,
  input  sw2pt_pkg::cfg_t                   cfg_i,
  input  logic [sw2pt_pkg::START_W-1:0]     start_i,
  output logic [sw2pt_pkg::PHI_WIDTH-1:0]   es_o,
  output sw2pt_pkg::phi_res_t               res_o
);
  import sw2pt_pkg::*;

  localparam logic [PAT_W-1:0] PAT_L2A = 4'd2;
  localparam logic [PAT_W-1:0] PAT_R2A = 4'd3;
  localparam logic [PAT_W-1:0] PAT_L2B = 4'd4;
  localparam logic [PAT_W-1:0] PAT_R2B = 4'd5;
  localparam logic [PAT_W-1:0] PAT_L1A = 4'd6;
  localparam logic [PAT_W-1:0] PAT_R1A = 4'd7;
  localparam logic [PAT_W-1:0] PAT_L1B = 4'd8;
  localparam logic [PAT_W-1:0] PAT_R1B = 4'd9;

  logic                 outer;
  logic [PHI_WIDTH-1:0] es_base;
  logic [FACTOR_W-1:0]  factor;
  logic [PROD_W-1:0]    prod;

  logic                 valid_q;
  logic                 outer_q;
  logic [PHI_WIDTH-1:0] scaled_q;

  logic [PHI_OUT_W-1:0] origin;
  logic [PHI_OUT_W-1:0] phi;
  logic [PHI_WIDTH-1:0] sum_r;
  logic [PHI_WIDTH-1:0] red;
  logic [HIT_OUT_W-1:0] hit;

  assign outer = halfstrip_i > HS_W'(HS_INNER_MAX);

  always_comb begin
    es_base = PHI_WIDTH'({halfstrip_i, 2'b00});
    if (outer) begin
      es_base = es_base - PHI_WIDTH'(OUTER_HS_OFFSET);
    end
    case (pattern_i)
      PAT_L2A, PAT_L2B: es_o = es_base - PHI_WIDTH'(2);
      PAT_R2A, PAT_R2B: es_o = es_base + PHI_WIDTH'(2);
      PAT_L1A, PAT_L1B: es_o = es_base - PHI_WIDTH'(1);
      PAT_R1A, PAT_R1B: es_o = es_base + PHI_WIDTH'(1);
      default:          es_o = es_base;
    endcase
    factor = outer ? FACTOR_OUTER : FACTOR_INNER;
    prod   = PROD_W'(es_o) * PROD_W'(factor);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      valid_q  <= valid_i;
      outer_q  <= outer;
      scaled_q <= prod[PHI_WIDTH+SCALE_SHIFT-1:SCALE_SHIFT];
    end
  end

  always_comb begin
    origin = outer_q ? cfg_i.phi_origin_outer : cfg_i.phi_origin_inner;
    phi    = cfg_i.reverse_mount ? origin - scaled_q[PHI_OUT_W-1:0]
                                 : origin + scaled_q[PHI_OUT_W-1:0];
    sum_r  = PHI_WIDTH'(phi) + PHI_WIDTH'(PHI_ROUND);
    red    = (sum_r >> RED_SHIFT) - PHI_WIDTH'(start_i);
    for (int k = 0; k < HIT_OUT_W; k++) begin
      hit[k] = valid_q && (k < HIT_MAP_WIDTH) && (red == PHI_WIDTH'(k));
    end
    res_o.valid = valid_q;
    res_o.outer = outer_q;
    res_o.phi   = valid_q ? phi : '0;
    res_o.hit   = hit;
  end

endmodule

`default_nettype wire

>>> design/sw2pt_tables.sv
// Wiregroup theta table and theta correction table with registered reads.
// The correction table is held twice so that four pairs read it each cycle that rd_en_i is high.
// Depends on sw2pt_pkg.
`default_nettype none

module sw2pt_tables (
  input  logic                                       clk_i,
  input  logic                                       wire_we_i,
  input  logic                                       corr_we_i,
  input  logic [sw2pt_pkg::CORR_AW-1:0]              wr_index_i,
  input  logic [sw2pt_pkg::WIRE_DW-1:0]              wr_value_i,
  input  logic                                       rd_en_i,
  input  logic [1:0][sw2pt_pkg::WIRE_AW-1:0]         wire_addr_i,
  input  logic [3:0][sw2pt_pkg::CORR_AW-1:0]         corr_addr_i,
  output logic [1:0][sw2pt_pkg::WIRE_DW-1:0]         wire_data_o,
  output logic [3:0][sw2pt_pkg::CORR_DW-1:0]         corr_data_o
);
  import sw2pt_pkg::*;

  logic [WIRE_DW-1:0] wire_mem   [WIRE_DEPTH];
  logic [CORR_DW-1:0] corr_mem_a [CORR_DEPTH];
  logic [CORR_DW-1:0] corr_mem_b [CORR_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wire_we_i) begin
      wire_mem[wr_index_i[WIRE_AW-1:0]] <= wr_value_i;
    end
    if (rd_en_i) begin
      wire_data_o[0] <= wire_mem[wire_addr_i[0]];
      wire_data_o[1] <= wire_mem[wire_addr_i[1]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (corr_we_i) begin
      corr_mem_a[wr_index_i] <= wr_value_i[CORR_DW-1:0];
    end
    if (rd_en_i) begin
      corr_data_o[0] <= corr_mem_a[corr_addr_i[0]];
      corr_data_o[1] <= corr_mem_a[corr_addr_i[1]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (corr_we_i) begin
      corr_mem_b[wr_index_i] <= wr_value_i[CORR_DW-1:0];
    end
    if (rd_en_i) begin
      corr_data_o[2] <= corr_mem_b[corr_addr_i[2]];
      corr_data_o[3] <= corr_mem_b[corr_addr_i[3]];
    end
  end

endmodule

`default_nettype wire

>>> design/sw2pt_theta_lane.sv
// One theta lane for a wire/strip segment pair: correction, clamp, offset
// and zone grading. Depends on sw2pt_pkg.
`default_nettype none

module sw2pt_theta_lane (
  input  logic                                both_valid_i,
  input  logic                                wg_zero_i,
  input  logic [sw2pt_pkg::WIRE_DW-1:0]       wire_theta_i,
  input  logic [sw2pt_pkg::CORR_DW-1:0]       corr_i,
  input  sw2pt_pkg::cfg_t                     cfg_i,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]   theta_o,
  output logic [sw2pt_pkg::ZONE_W-1:0]        zone_o
);
  import sw2pt_pkg::*;

  logic [THETA_WIDTH-1:0] sum;
  logic [THETA_WIDTH-1:0] clamped;
  logic [THETA_WIDTH-1:0] t;
  logic [ZONE_W-1:0]      zone;

  always_comb begin
    sum = cfg_i.reverse_mount ? THETA_WIDTH'(wire_theta_i) - THETA_WIDTH'(corr_i)
                              : THETA_WIDTH'(wire_theta_i) + THETA_WIDTH'(corr_i);
    if (sum > THETA_CUT || wg_zero_i) begin
      clamped = '0;
    end else if (sum > THETA_MAX) begin
      clamped = THETA_WIDTH'(THETA_MAX);
    end else begin
      clamped = sum;
    end
    t = clamped + THETA_WIDTH'(cfg_i.theta_origin);
    if (t == '0) begin
      t = THETA_WIDTH'(1);
    end
    zone            = '0;
    zone[ZONE_LOW]  = t <= ZONE_LOW_MAX;
    zone[ZONE_HIGH] = t > ZONE_HIGH_MIN;
    zone[ZONE_MID]  = (t > ZONE_MID_MIN) && (t <= ZONE_MID_MAX);
    theta_o = both_valid_i ? THETA_OUT_W'(t) : '0;
    zone_o  = both_valid_i ? zone : '0;
  end

endmodule

`default_nettype wire

>>> design/sw2pt_merge.sv
// Merging stage and output register: combines the lane results into one
// result transaction and holds it until taken. Depends on sw2pt_pkg.
`default_nettype none

module sw2pt_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s1_valid_i,
  input  sw2pt_pkg::phi_res_t [1:0]                 phi_res_i,
  input  logic [1:0][sw2pt_pkg::PAT_W-1:0]          pattern_i,
  input  logic [3:0][sw2pt_pkg::THETA_OUT_W-1:0]    theta_i,
  input  logic [3:0][sw2pt_pkg::ZONE_W-1:0]         zone_i,
  input  logic                                      out_ready_i,
  output logic                                      take_o,
  output logic                                      out_valid_o,
  output logic [sw2pt_pkg::PHI_OUT_W-1:0]           phi0_o,
  output logic [sw2pt_pkg::PHI_OUT_W-1:0]           phi1_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]         theta_00_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]         theta_01_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]         theta_10_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]         theta_11_o,
  output logic                                      any_valid_o,
  output logic [sw2pt_pkg::ZONE_W-1:0]              zone_mask_o,
  output logic                                      outer_region_o,
  output logic [sw2pt_pkg::HIT_OUT_W-1:0]           phi_hit_map_o,
  output logic [sw2pt_pkg::PAT_W-1:0]               pattern_out0_o,
  output logic [sw2pt_pkg::PAT_W-1:0]               pattern_out1_o
);
  import sw2pt_pkg::*;

  logic                              out_valid_q;
  logic [1:0][PHI_OUT_W-1:0]         phi_q;
  logic [3:0][THETA_OUT_W-1:0]       theta_q;
  logic                              any_valid_q;
  logic [ZONE_W-1:0]                 zone_q;
  logic                              outer_q;
  logic [HIT_OUT_W-1:0]              hit_q;
  logic [1:0][PAT_W-1:0]             pattern_q;

  assign take_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      phi_q[0]    <= phi_res_i[0].phi;
      phi_q[1]    <= phi_res_i[1].phi;
      theta_q     <= theta_i;
      any_valid_q <= phi_res_i[0].valid | phi_res_i[1].valid;
      zone_q      <= zone_i[0] | zone_i[1] | zone_i[2] | zone_i[3];
      outer_q     <= phi_res_i[1].outer;
      hit_q       <= phi_res_i[0].hit | phi_res_i[1].hit;
      pattern_q   <= pattern_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phi0_o         = phi_q[0];
  assign phi1_o         = phi_q[1];
  assign theta_00_o     = theta_q[0];
  assign theta_01_o     = theta_q[1];
  assign theta_10_o     = theta_q[2];
  assign theta_11_o     = theta_q[3];
  assign any_valid_o    = any_valid_q;
  assign zone_mask_o    = zone_q;
  assign outer_region_o = outer_q;
  assign phi_hit_map_o  = hit_q;
  assign pattern_out0_o = pattern_q[0];
  assign pattern_out1_o = pattern_q[1];

endmodule

`default_nettype wire

>>> design/strip_wire_to_phi_theta.sv
// Strip/wire to phi/theta converter, top level. Uses sw2pt_pkg and all sw2pt modules.
// A transaction is registered in the middle stage when it is accepted, then in the
// output register once the output stage takes it.
// Throughput: one transaction per cycle while in_ready_o is high; a result waiting
// at the output does not block acceptance while the middle stage is free.
// Reset clears the pipeline valids and the configuration; tables stay undefined until written.
`default_nettype none

module strip_wire_to_phi_theta (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sw2pt_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [sw2pt_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [sw2pt_pkg::REQ_W-1:0]            req_type_i,
  input  logic                                   seg0_valid_i,
  input  logic                                   seg1_valid_i,
  input  logic [sw2pt_pkg::HS_W-1:0]             seg0_halfstrip_i,
  input  logic [sw2pt_pkg::HS_W-1:0]             seg1_halfstrip_i,
  input  logic [sw2pt_pkg::WG_W-1:0]             seg0_wiregroup_i,
  input  logic [sw2pt_pkg::WG_W-1:0]             seg1_wiregroup_i,
  input  logic [sw2pt_pkg::PAT_W-1:0]            seg0_pattern_i,
  input  logic [sw2pt_pkg::PAT_W-1:0]            seg1_pattern_i,
  input  logic [sw2pt_pkg::CORR_AW-1:0]          table_index_i,
  input  logic [sw2pt_pkg::WIRE_DW-1:0]          table_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [sw2pt_pkg::PHI_OUT_W-1:0]        phi0_o,
  output logic [sw2pt_pkg::PHI_OUT_W-1:0]        phi1_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]      theta_00_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]      theta_01_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]      theta_10_o,
  output logic [sw2pt_pkg::THETA_OUT_W-1:0]      theta_11_o,
  output logic                                   any_valid_o,
  output logic [sw2pt_pkg::ZONE_W-1:0]           zone_mask_o,
  output logic                                   outer_region_o,
  output logic [sw2pt_pkg::HIT_OUT_W-1:0]        phi_hit_map_o,
  output logic [sw2pt_pkg::PAT_W-1:0]            pattern_out0_o,
  output logic [sw2pt_pkg::PAT_W-1:0]            pattern_out1_o
);
  import sw2pt_pkg::*;

  cfg_t cfg_q;

  logic in_acc;
  logic take;
  logic s1_load;
  logic s1_valid_q;
  logic [1:0] wg_zero_q;
  logic [1:0][PAT_W-1:0] pattern_q;

  logic [START_W-1:0] start;
  logic [1:0] seg_valid;
  logic [1:0][HS_W-1:0] seg_hs;
  logic [1:0][WG_W-1:0] seg_wg;
  logic [1:0][PAT_W-1:0] seg_pat;
  logic [1:0][PHI_WIDTH-1:0] es;
  phi_res_t [1:0] phi_res;

  logic [1:0][WIRE_AW-1:0] wire_addr;
  logic [3:0][CORR_AW-1:0] corr_addr;
  logic [1:0][WIRE_DW-1:0] wire_data;
  logic [3:0][CORR_DW-1:0] corr_data;
  logic [3:0][THETA_OUT_W-1:0] theta;
  logic [3:0][ZONE_W-1:0] zone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PHI_INNER: cfg_q.phi_origin_inner <= cfg_wdata_i;
        CFG_PHI_OUTER: cfg_q.phi_origin_outer <= cfg_wdata_i;
        CFG_THETA_ORG: cfg_q.theta_origin     <= cfg_wdata_i[6:0];
        CFG_STATION:   cfg_q.station_number   <= cfg_wdata_i[2:0];
        CFG_CHAMBER:   cfg_q.chamber_number   <= cfg_wdata_i[3:0];
        CFG_REVERSE:   cfg_q.reverse_mount    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign s1_load    = take || !s1_valid_q;
  assign in_ready_o = s1_load;
  assign in_acc     = in_valid_i && s1_load;
  assign start      = chamber_start(cfg_q.station_number, cfg_q.chamber_number);

  assign seg_valid = {seg1_valid_i, seg0_valid_i};
  assign seg_hs    = {seg1_halfstrip_i, seg0_halfstrip_i};
  assign seg_wg    = {seg1_wiregroup_i, seg0_wiregroup_i};
  assign seg_pat   = {seg1_pattern_i, seg0_pattern_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_acc && (req_type_i == REQ_CONVERT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      wg_zero_q[0] <= seg0_wiregroup_i == '0;
      wg_zero_q[1] <= seg1_wiregroup_i == '0;
      pattern_q    <= seg_pat;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_phi
    sw2pt_phi_lane u_phi_lane (
      .clk_i      (clk_i),
      .ld_i       (s1_load),
      .valid_i    (seg_valid[g]),
      .halfstrip_i(seg_hs[g]),
      .pattern_i  (seg_pat[g]),
      .cfg_i      (cfg_q),
      .start_i    (start),
      .es_o       (es[g]),
      .res_o      (phi_res[g])
    );
    assign wire_addr[g] = seg_wg[g];
  end

  // Pair p uses wire segment p % 2 and strip segment p / 2.
  for (genvar p = 0; p < 4; p++) begin : g_addr
    assign corr_addr[p] = {seg_wg[p % 2][WG_W-1:WG_W-2], es[p / 2][8:4]};
  end

  sw2pt_tables u_tables (
    .clk_i      (clk_i),
    .wire_we_i  (in_acc && (req_type_i == REQ_WIRE_WR)
                 && (table_index_i < CORR_AW'(WIRE_DEPTH))),
    .corr_we_i  (in_acc && (req_type_i == REQ_CORR_WR)),
    .wr_index_i (table_index_i),
    .wr_value_i (table_value_i),
    .rd_en_i    (s1_load),
    .wire_addr_i(wire_addr),
    .corr_addr_i(corr_addr),
    .wire_data_o(wire_data),
    .corr_data_o(corr_data)
  );

  for (genvar p = 0; p < 4; p++) begin : g_theta
    sw2pt_theta_lane u_theta_lane (
      .both_valid_i(phi_res[p % 2].valid && phi_res[p / 2].valid),
      .wg_zero_i   (wg_zero_q[p % 2]),
      .wire_theta_i(wire_data[p % 2]),
      .corr_i      (corr_data[p]),
      .cfg_i       (cfg_q),
      .theta_o     (theta[p]),
      .zone_o      (zone[p])
    );
  end

  sw2pt_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid_q),
    .phi_res_i     (phi_res),
    .pattern_i     (pattern_q),
    .theta_i       (theta),
    .zone_i        (zone),
    .out_ready_i   (out_ready_i),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .phi0_o        (phi0_o),
    .phi1_o        (phi1_o),
    .theta_00_o    (theta_00_o),
    .theta_01_o    (theta_01_o),
    .theta_10_o    (theta_10_o),
    .theta_11_o    (theta_11_o),
    .any_valid_o   (any_valid_o),
    .zone_mask_o   (zone_mask_o),
    .outer_region_o(outer_region_o),
    .phi_hit_map_o (phi_hit_map_o),
    .pattern_out0_o(pattern_out0_o),
    .pattern_out1_o(pattern_out1_o)
  );

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !take) |=> s1_valid_q)
    else $error("middle stage transaction dropped while output stalled");

  a_table_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_type_i != REQ_CONVERT)) |=> !s1_valid_q)
    else $error("non-conversion transaction produced a result");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !any_valid_o) |-> (phi_hit_map_o == '0 && zone_mask_o == '0
                                       && phi0_o == '0 && phi1_o == '0))
    else $error("result without valid segments carries hits or zones");

endmodule

`default_nettype wire

>>> dv/tb_strip_wire_to_phi_theta.sv
`timescale 1ns / 1ps
// Self-checking testbench for strip_wire_to_phi_theta: directed and random transactions,
// with results checked against typed-in rows or the behavioral predictor in this file.
// Depends on sw2pt_pkg and the strip_wire_to_phi_theta RTL.

module tb_strip_wire_to_phi_theta;
  import sw2pt_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 265;
  localparam int LONG_HOLD       = 400;
  localparam int DIRECTED_ROWS   = 21;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned CHAMBER_PHI_START [5][16] = '{
    '{39, 57, 76, 39, 58, 76, 41, 60, 79, 39, 57, 76, 21, 21, 23, 21},
    '{95, 114, 132, 95, 114, 133, 98, 116, 135, 95, 114, 132, 0, 0, 0, 0},
    '{38, 76, 113, 39, 58, 76, 95, 114, 132, 1, 21, 0, 0, 0, 0, 0},
    '{38, 76, 113, 39, 58, 76, 95, 114, 132, 1, 21, 0, 0, 0, 0, 0},
    '{38, 76, 113, 38, 57, 76, 95, 113, 132, 1, 20, 0, 0, 0, 0, 0}
  };

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic               seg0_valid;
    logic               seg1_valid;
    logic [HS_W-1:0]    seg0_halfstrip;
    logic [HS_W-1:0]    seg1_halfstrip;
    logic [WG_W-1:0]    seg0_wiregroup;
    logic [WG_W-1:0]    seg1_wiregroup;
    logic [PAT_W-1:0]   seg0_pattern;
    logic [PAT_W-1:0]   seg1_pattern;
    logic [CORR_AW-1:0] table_index;
    logic [WIRE_DW-1:0] table_value;
  } sw_item_t;

  typedef struct packed {
    logic [PHI_OUT_W-1:0]   phi0;
    logic [PHI_OUT_W-1:0]   phi1;
    logic [THETA_OUT_W-1:0] theta_00;
    logic [THETA_OUT_W-1:0] theta_01;
    logic [THETA_OUT_W-1:0] theta_10;
    logic [THETA_OUT_W-1:0] theta_11;
    logic                   any_valid;
    logic [ZONE_W-1:0]      zone_mask;
    logic                   outer_region;
    logic [HIT_OUT_W-1:0]   phi_hit_map;
    logic [PAT_W-1:0]       pattern_out0;
    logic [PAT_W-1:0]       pattern_out1;
  } pt_result_t;

  typedef struct packed {
    sw_item_t   item;
    logic       known;
    pt_result_t result;
  } directed_row_t;

  // Rows with a typed-in result run under the all-zero configuration.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{REQ_CONVERT, 0, 0, 255, 255, 63, 63, 15, 15, 0, 0}, 1,
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 15, 15}},
    '{'{REQ_CONVERT, 0, 0, 0, 127, 0, 0, 0, 0, 0, 0}, 1, '0},
    '{'{REQ_WIRE_WR, 0, 0, 0, 0, 0, 0, 0, 0, 40, 63}, 0, '0},
    '{'{REQ_CORR_WR, 0, 0, 0, 0, 0, 0, 0, 0, 64, 16}, 0, '0},
    '{'{REQ_CONVERT, 1, 0, 0, 0, 40, 0, 0, 0, 0, 0}, 1,
      '{0, 0, 1, 0, 0, 0, 1, 1, 0, 0, 0, 0}},
    '{'{REQ_WIRE_WR, 0, 0, 0, 0, 0, 0, 0, 0, 41, 48}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 0, 0, 40, 41, 0, 0, 0, 0}, 1,
      '{0, 0, 1, 45, 1, 45, 1, 3, 0, 0, 0, 0}},
    '{'{REQ_WIRE_WR, 0, 0, 0, 0, 0, 0, 0, 0, 63, 0}, 0, '0},
    '{'{REQ_WIRE_WR, 0, 0, 0, 0, 0, 0, 0, 0, 127, 63}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 255, 128, 63, 63, 15, 1, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 127, 128, 5, 22, 2, 3, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 0, 1, 33, 12, 4, 5, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 200, 64, 50, 7, 6, 7, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 128, 0, 19, 60, 8, 9, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 85, 170, 42, 21, 10, 14, 0, 0}, 0, '0},
    '{'{REQ_UNUSED, 1, 1, 255, 255, 63, 63, 15, 15, 127, 63}, 0, '0},
    '{'{REQ_CORR_WR, 0, 0, 0, 0, 0, 0, 0, 0, 127, 63}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 255, 255, 0, 48, 0, 0, 0, 0}, 0, '0},
    '{'{REQ_CONVERT, 0, 1, 0, 64, 0, 17, 0, 12, 0, 0}, 0, '0},
    '{'{REQ_CORR_WR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15}, 0, '0},
    '{'{REQ_CONVERT, 1, 1, 0, 2, 1, 2, 0, 11, 0, 0}, 0, '0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [REQ_W-1:0]       req_type_i;
  logic                   seg0_valid_i;
  logic                   seg1_valid_i;
  logic [HS_W-1:0]        seg0_halfstrip_i;
  logic [HS_W-1:0]        seg1_halfstrip_i;
  logic [WG_W-1:0]        seg0_wiregroup_i;
  logic [WG_W-1:0]        seg1_wiregroup_i;
  logic [PAT_W-1:0]       seg0_pattern_i;
  logic [PAT_W-1:0]       seg1_pattern_i;
  logic [CORR_AW-1:0]     table_index_i;
  logic [WIRE_DW-1:0]     table_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [PHI_OUT_W-1:0]   phi0_o;
  logic [PHI_OUT_W-1:0]   phi1_o;
  logic [THETA_OUT_W-1:0] theta_00_o;
  logic [THETA_OUT_W-1:0] theta_01_o;
  logic [THETA_OUT_W-1:0] theta_10_o;
  logic [THETA_OUT_W-1:0] theta_11_o;
  logic                   any_valid_o;
  logic [ZONE_W-1:0]      zone_mask_o;
  logic                   outer_region_o;
  logic [HIT_OUT_W-1:0]   phi_hit_map_o;
  logic [PAT_W-1:0]       pattern_out0_o;
  logic [PAT_W-1:0]       pattern_out1_o;

  cfg_t               cfg_model;
  logic [WIRE_DW-1:0] wire_theta_mem [WIRE_DEPTH];
  logic [CORR_DW-1:0] corr_mem [CORR_DEPTH];
  pt_result_t         expected_phi_theta [$];

  int unsigned mismatches = 0;
  int unsigned sender_gap_pct = 0;
  int unsigned receiver_gap_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  strip_wire_to_phi_theta i_dut (.*);

  always #CLK_HALF clk_i = ~clk_i;

  function automatic bit predict_phi_theta(input sw_item_t it, output pt_result_t r);
    logic                   vld [2];
    logic [HS_W-1:0]        hs [2];
    logic [WG_W-1:0]        wg [2];
    logic [PAT_W-1:0]       pat [2];
    logic [PHI_WIDTH-1:0]   es [2];
    logic [PHI_OUT_W-1:0]   phi [2];
    logic [THETA_WIDTH-1:0] th [2][2];
    logic [PHI_WIDTH-1:0]   start, scaled, rounded, red;
    logic [PHI_OUT_W-1:0]   origin;
    logic [THETA_WIDTH-1:0] t;
    logic [WIRE_DW-1:0]     base;
    logic [CORR_DW-1:0]     corr;
    logic [ZONE_W-1:0]      zone;
    logic [HIT_OUT_W-1:0]   hit;
    int unsigned            factor, step;
    r = '0;
    if (it.req == REQ_WIRE_WR) begin
      if (it.table_index < WIRE_DEPTH) begin
        wire_theta_mem[it.table_index[WIRE_AW-1:0]] = it.table_value;
      end
      return 1'b0;
    end
    if (it.req == REQ_CORR_WR) begin
      corr_mem[it.table_index] = it.table_value[CORR_DW-1:0];
      return 1'b0;
    end
    if (it.req != REQ_CONVERT) begin
      return 1'b0;
    end

    vld = '{it.seg0_valid, it.seg1_valid};
    hs  = '{it.seg0_halfstrip, it.seg1_halfstrip};
    wg  = '{it.seg0_wiregroup, it.seg1_wiregroup};
    pat = '{it.seg0_pattern, it.seg1_pattern};
    start = '0;
    if (cfg_model.station_number < 5) begin
      start = PHI_WIDTH'(CHAMBER_PHI_START[cfg_model.station_number][cfg_model.chamber_number]
                         % 128);
    end
    zone = '0;
    hit = '0;

    for (int k = 0; k < 2; k++) begin
      es[k] = PHI_WIDTH'({hs[k], 2'b00});
      if (hs[k] > 127) begin
        es[k] = PHI_WIDTH'(es[k] - 512);
        factor = 1707;
        origin = cfg_model.phi_origin_outer;
      end else begin
        factor = 1301;
        origin = cfg_model.phi_origin_inner;
      end
      step = (pat[k] >= 2 && pat[k] <= 5) ? 2 : (pat[k] >= 6 && pat[k] <= 9) ? 1 : 0;
      if (step != 0 && !pat[k][0]) begin
        es[k] = PHI_WIDTH'(es[k] - step);
      end else begin
        es[k] = PHI_WIDTH'(es[k] + step);
      end
      phi[k] = '0;
      if (vld[k]) begin
        scaled = PHI_WIDTH'((es[k] * factor) >> 10);
        phi[k] = cfg_model.reverse_mount ? PHI_OUT_W'(origin - scaled)
                                         : PHI_OUT_W'(origin + scaled);
        rounded = phi[k] + 13'd16;
        red = (rounded >> 5) - start;
        if (red < HIT_OUT_W) begin
          hit[red] = 1'b1;
        end
      end
    end

    for (int w = 0; w < 2; w++) begin
      for (int s = 0; s < 2; s++) begin
        th[w][s] = '0;
        if (vld[w] && vld[s]) begin
          base = wire_theta_mem[wg[w]];
          corr = corr_mem[{wg[w][5:4], es[s][8:4]}];
          t = cfg_model.reverse_mount ? base - corr : base + corr;
          if (t > 50 || wg[w] == 0) begin
            t = '0;
          end
          if (t > 45) begin
            t = 7'd45;
          end
          t = t + cfg_model.theta_origin;
          if (t == 0) begin
            t = 7'd1;
          end
          th[w][s] = t;
          if (t <= 43) begin
            zone[0] = 1'b1;
          end
          if (t > 125) begin
            zone[2] = 1'b1;
          end
          if (t > 39 && t <= 129) begin
            zone[1] = 1'b1;
          end
        end
      end
    end

    r.phi0         = phi[0];
    r.phi1         = phi[1];
    r.theta_00     = th[0][0];
    r.theta_01     = th[1][0];
    r.theta_10     = th[0][1];
    r.theta_11     = th[1][1];
    r.any_valid    = vld[0] | vld[1];
    r.zone_mask    = zone;
    r.outer_region = hs[1] > 127;
    r.phi_hit_map  = hit;
    r.pattern_out0 = pat[0];
    r.pattern_out1 = pat[1];
    return 1'b1;
  endfunction

  function automatic logic [HS_W-1:0] pick_halfstrip();
    logic [HS_W-1:0] boundary [4];
    boundary = '{8'd0, 8'd127, 8'd128, 8'd255};
    if ($urandom_range(7) == 0) begin
      return boundary[$urandom_range(3)];
    end
    return HS_W'($urandom_range(255));
  endfunction

  function automatic sw_item_t random_item();
    sw_item_t    it;
    int unsigned pick;
    it.seg0_valid     = $urandom_range(3) != 0;
    it.seg1_valid     = $urandom_range(3) != 0;
    it.seg0_halfstrip = pick_halfstrip();
    it.seg1_halfstrip = pick_halfstrip();
    it.seg0_wiregroup = WG_W'($urandom_range(63));
    it.seg1_wiregroup = WG_W'($urandom_range(63));
    it.seg0_pattern   = PAT_W'($urandom_range(15));
    it.seg1_pattern   = PAT_W'($urandom_range(15));
    it.table_index    = CORR_AW'($urandom_range(127));
    it.table_value    = WIRE_DW'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 80) begin
      it.req = REQ_CONVERT;
    end else if (pick < 90) begin
      it.req = REQ_WIRE_WR;
    end else if (pick < 98) begin
      it.req = REQ_CORR_WR;
    end else begin
      it.req = REQ_UNUSED;
    end
    return it;
  endfunction

  function automatic cfg_t random_settings(input int unsigned station_max);
    cfg_t c;
    c.phi_origin_inner = 12'($urandom_range(4095));
    c.phi_origin_outer = 12'($urandom_range(4095));
    c.theta_origin     = 7'($urandom_range(127));
    c.station_number   = 3'($urandom_range(station_max));
    c.chamber_number   = 4'($urandom_range(15));
    c.reverse_mount    = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Registers are written back to back; the enable drops after the last one.
  task automatic apply_settings(input cfg_t c);
    logic [CFG_ADDR_W-1:0] addr [6];
    logic [CFG_DATA_W-1:0] data [6];
    addr = '{CFG_PHI_INNER, CFG_PHI_OUTER, CFG_THETA_ORG, CFG_STATION, CFG_CHAMBER,
             CFG_REVERSE};
    data = '{c.phi_origin_inner, CFG_DATA_W'(c.phi_origin_outer),
             CFG_DATA_W'(c.theta_origin), CFG_DATA_W'(c.station_number),
             CFG_DATA_W'(c.chamber_number), CFG_DATA_W'(c.reverse_mount)};
    for (int k = 0; k < 6; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= addr[k];
      cfg_wdata_i <= data[k];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    cfg_model = c;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic offer(input sw_item_t it, input logic known, input pt_result_t golden);
    pt_result_t res;
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= it.req;
    seg0_valid_i     <= it.seg0_valid;
    seg1_valid_i     <= it.seg1_valid;
    seg0_halfstrip_i <= it.seg0_halfstrip;
    seg1_halfstrip_i <= it.seg1_halfstrip;
    seg0_wiregroup_i <= it.seg0_wiregroup;
    seg1_wiregroup_i <= it.seg1_wiregroup;
    seg0_pattern_i   <= it.seg0_pattern;
    seg1_pattern_i   <= it.seg1_pattern;
    table_index_i    <= it.table_index;
    table_value_i    <= it.table_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_phi_theta(it, res)) begin
      expected_phi_theta.push_back(known ? golden : res);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_phi_theta.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : receive
    pt_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_phi_theta.size() == 0) begin
        $display("%0t: result transaction expected none, got phi0 0x%0h phi1 0x%0h",
                 $time, phi0_o, phi1_o);
        mismatches++;
      end else begin
        want = expected_phi_theta.pop_front();
        check_field("phi0", want.phi0, phi0_o);
        check_field("phi1", want.phi1, phi1_o);
        check_field("theta_00", want.theta_00, theta_00_o);
        check_field("theta_01", want.theta_01, theta_01_o);
        check_field("theta_10", want.theta_10, theta_10_o);
        check_field("theta_11", want.theta_11, theta_11_o);
        check_field("any_valid", want.any_valid, any_valid_o);
        check_field("zone_mask", want.zone_mask, zone_mask_o);
        check_field("outer_region", want.outer_region, outer_region_o);
        check_field("phi_hit_map", want.phi_hit_map, phi_hit_map_o);
        check_field("pattern_out0", want.pattern_out0, pattern_out0_o);
        check_field("pattern_out1", want.pattern_out1, pattern_out1_o);
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= receiver_gap_pct;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    cfg_t settings;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_addr_i       = '0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_CONVERT;
    seg0_valid_i     = 1'b0;
    seg1_valid_i     = 1'b0;
    seg0_halfstrip_i = '0;
    seg1_halfstrip_i = '0;
    seg0_wiregroup_i = '0;
    seg1_wiregroup_i = '0;
    seg0_pattern_i   = '0;
    seg1_pattern_i   = '0;
    table_index_i    = '0;
    table_value_i    = '0;
    cfg_model        = '0;
    sender_gap_pct   = 15;
    receiver_gap_pct = 55;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_settings('0);

    // Both tables are loaded in full so no conversion reads an unwritten entry.
    for (int k = 0; k < WIRE_DEPTH; k++) begin
      offer('{REQ_WIRE_WR, 0, 0, 0, 0, 0, 0, 0, 0, CORR_AW'(k), WIRE_DW'($urandom_range(63))},
            1'b0, '0);
    end
    for (int k = 0; k < CORR_DEPTH; k++) begin
      offer('{REQ_CORR_WR, 0, 0, 0, 0, 0, 0, 0, 0, CORR_AW'(k), WIRE_DW'($urandom_range(63))},
            1'b0, '0);
    end
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      offer(DIRECTED[k].item, DIRECTED[k].known, DIRECTED[k].result);
    end
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        sender_gap_pct   = 15;
        receiver_gap_pct = 55;
      end else if (phase < 4) begin
        sender_gap_pct   = 55;
        receiver_gap_pct = 15;
      end else begin
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
      end
      case (phase)
        1: settings = '{12'hfff, 12'hfff, 7'h7f, 3'd4, 4'hf, 1'b1};
        2: settings = '0;
        3: begin
          settings = random_settings(4);
          settings.station_number = 3'($urandom_range(7, 5));
        end
        4: settings = random_settings(7);
        default: settings = random_settings(4);
      endcase
      apply_settings(settings);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == 100) begin
          hold_requests++;
        end
        offer(random_item(), 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
